>>> sv/thumb_alu_execute_assert.svh
// ----------------------------------------------------------------------------
// Thumb ALU execute assertion macros
// Concurrent assertion wrappers shared by the execute stage RTL.
// ----------------------------------------------------------------------------
`ifndef THUMB_ALU_EXECUTE_ASSERT_SVH
`define THUMB_ALU_EXECUTE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset
`define TAE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every clock edge, reset included
`define TAE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAE_ASSERT(label, clk, rstn, prop, msg)
`define TAE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> sv/tae_pkg.sv
// ----------------------------------------------------------------------------
// Thumb ALU execute package
// Transaction types, register file sizes, item kinds and format decode.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = 4;
    localparam int FLAGS_W   = 4;

    localparam logic [REG_AW-1:0] REG_SP = 4'd13;

    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] FMT_NONE   = 3'd0;
    localparam logic [2:0] FMT_SHIFT  = 3'd1;
    localparam logic [2:0] FMT_ADDSUB = 3'd2;
    localparam logic [2:0] FMT_IMM    = 3'd3;
    localparam logic [2:0] FMT_ALU    = 3'd4;
    localparam logic [2:0] FMT_HI     = 3'd5;
    localparam logic [2:0] FMT_ADDR   = 3'd6;
    localparam logic [2:0] FMT_SP     = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       instruction;
        logic [REG_AW-1:0] reg_index;
        logic [DATA_W-1:0] write_value;
        logic [DATA_W-1:0] pc_value;
    } tae_in_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result_value;
        logic [REG_AW-1:0]  dest_index;
        logic               dest_written;
        logic [FLAGS_W-1:0] flags_out;
        logic               unsupported;
    } tae_out_t;

    typedef struct packed {
        logic [REG_AW-1:0] addr_a;
        logic [REG_AW-1:0] addr_b;
    } tae_rd_addr_t;

    function automatic logic [2:0] tae_format(logic [15:0] ins);
        logic [2:0] fmt;
        if (ins[15:11] == 5'b00011) begin
            fmt = FMT_ADDSUB;
        end else if (ins[15:13] == 3'b000) begin
            fmt = FMT_SHIFT;
        end else if (ins[15:13] == 3'b001) begin
            fmt = FMT_IMM;
        end else if (ins[15:10] == 6'b010000) begin
            fmt = FMT_ALU;
        end else if (ins[15:10] == 6'b010001 && ins[9:8] != 2'b11) begin
            fmt = FMT_HI;
        end else if (ins[15:12] == 4'b1010) begin
            fmt = FMT_ADDR;
        end else if (ins[15:8] == 8'hB0) begin
            fmt = FMT_SP;
        end else begin
            fmt = FMT_NONE;
        end
        return fmt;
    endfunction

    // Operand A / B register numbers for an incoming transaction
    function automatic tae_rd_addr_t tae_read_addrs(tae_in_t item);
        tae_rd_addr_t ra;
        logic [15:0]  ins;
        ins = item.instruction;
        ra.addr_a = {1'b0, ins[5:3]};
        ra.addr_b = {1'b0, ins[8:6]};
        if (item.kind == KIND_READ || item.kind == KIND_WRITE) begin
            ra.addr_a = item.reg_index;
        end else begin
            case (tae_format(ins))
                FMT_IMM: begin
                    ra.addr_a = {1'b0, ins[10:8]};
                end
                FMT_ALU: begin
                    ra.addr_a = {1'b0, ins[2:0]};
                    ra.addr_b = {1'b0, ins[5:3]};
                end
                FMT_HI: begin
                    ra.addr_a = {ins[7], ins[2:0]};
                    ra.addr_b = ins[6:3];
                end
                FMT_ADDR, FMT_SP: begin
                    ra.addr_a = REG_SP;
                end
                default: begin
                end
            endcase
        end
        return ra;
    endfunction

endpackage

>>> sv/tae_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> sv/tae_regfile.sv
// ----------------------------------------------------------------------------
// Thumb ALU register file
// 16 x 32 RAM with per-entry valid bits (unwritten reads as zero) and a
// bypass for a write landing on the same edge as the read.
// ----------------------------------------------------------------------------
module tae_regfile import tae_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  tae_rd_addr_t      rd_addr,
    input  logic              wr_en,
    input  logic [REG_AW-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] op_a,
    output logic [DATA_W-1:0] op_b
);

    logic [REG_COUNT-1:0] valid_reg;
    logic                 hit_a_reg;
    logic                 hit_b_reg;
    logic                 live_a_reg;
    logic                 live_b_reg;
    logic [DATA_W-1:0]    byp_data_reg;
    logic [DATA_W-1:0]    ram_a;
    logic [DATA_W-1:0]    ram_b;

    tae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr.addr_a),
        .rd_addr_b (rd_addr.addr_b),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_a_reg    <= wr_en && (wr_addr == rd_addr.addr_a);
            hit_b_reg    <= wr_en && (wr_addr == rd_addr.addr_b);
            live_a_reg   <= valid_reg[rd_addr.addr_a];
            live_b_reg   <= valid_reg[rd_addr.addr_b];
            byp_data_reg <= wr_data;
        end
    end

    assign op_a = hit_a_reg ? byp_data_reg : (live_a_reg ? ram_a : '0);
    assign op_b = hit_b_reg ? byp_data_reg : (live_b_reg ? ram_b : '0);

endmodule

>>> sv/tae_alu.sv
// ----------------------------------------------------------------------------
// Thumb ALU datapath
// Decode, shared adder, barrel shifter, multiplier and NZCV update.
// ----------------------------------------------------------------------------
module tae_alu import tae_pkg::*; (
    input  tae_in_t            item,
    input  logic [DATA_W-1:0]  op_a,
    input  logic [DATA_W-1:0]  op_b,
    input  logic [FLAGS_W-1:0] flags,
    output tae_out_t           res
);

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_LSL = 4'd2;
    localparam logic [3:0] OP_LSR = 4'd3;
    localparam logic [3:0] OP_ASR = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_ROR = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_NEG = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MUL = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [1:0] HI_ADD = 2'd0;
    localparam logic [1:0] HI_CMP = 2'd1;

    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;

    logic [15:0]       ins;
    logic [2:0]        fmt;
    logic [3:0]        alu_op;
    logic              c_in;

    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_cin;
    logic [DATA_W:0]   add_sum;
    logic              add_v;

    logic [DATA_W-1:0] sh_val;
    logic [7:0]        sh_amt;
    logic [1:0]        sh_kind;
    logic [DATA_W-1:0] sh_res;
    logic              sh_c;
    logic [2*DATA_W-1:0] rot;
    logic [DATA_W:0]   asr_ext;

    logic [DATA_W-1:0] mul_res;

    logic [DATA_W-1:0] r;
    logic [REG_AW-1:0] d;
    logic              w;
    logic              unsup;
    logic              upd_add;
    logic              upd_sh;
    logic              upd_nz;
    logic [FLAGS_W-1:0] fl;

    assign ins    = item.instruction;
    assign fmt    = tae_format(ins);
    assign alu_op = ins[9:6];
    assign c_in   = flags[1];

    // Adder operand selection
    always_comb begin
        add_x   = op_a;
        add_y   = op_b;
        add_cin = 1'b0;
        case (fmt)
            FMT_ADDSUB: begin
                add_y = ins[10] ? {29'd0, ins[8:6]} : op_b;
                if (ins[9]) begin
                    add_y   = ~add_y;
                    add_cin = 1'b1;
                end
            end
            FMT_IMM: begin
                add_y = {24'd0, ins[7:0]};
                if (ins[12:11] != IMM_ADD) begin
                    add_y   = ~add_y;
                    add_cin = 1'b1;
                end
            end
            FMT_ALU: begin
                case (alu_op)
                    OP_ADC: begin
                        add_cin = c_in;
                    end
                    OP_SBC: begin
                        add_y   = ~op_b;
                        add_cin = c_in;
                    end
                    OP_NEG: begin
                        add_x   = '0;
                        add_y   = ~op_b;
                        add_cin = 1'b1;
                    end
                    OP_CMP: begin
                        add_y   = ~op_b;
                        add_cin = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            FMT_HI: begin
                if (ins[9:8] == HI_CMP) begin
                    add_y   = ~op_b;
                    add_cin = 1'b1;
                end
            end
            FMT_ADDR: begin
                add_x = ins[11] ? op_a : {item.pc_value[DATA_W-1:2], 2'b00};
                add_y = {22'd0, ins[7:0], 2'b00};
            end
            FMT_SP: begin
                add_y = {23'd0, ins[6:0], 2'b00};
                if (ins[7]) begin
                    add_y   = ~add_y;
                    add_cin = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign add_v   = (~(add_x[DATA_W-1] ^ add_y[DATA_W-1]))
                   & (add_x[DATA_W-1] ^ add_sum[DATA_W-1]);

    assign mul_res = op_a * op_b;

    // Shifter input selection; immediate lsr/asr by zero means by 32
    always_comb begin
        sh_val = op_a;
        if (fmt == FMT_SHIFT) begin
            sh_kind = ins[12:11];
            if (ins[10:6] == 5'd0 && ins[12:11] != SH_LSL) begin
                sh_amt = 8'd32;
            end else begin
                sh_amt = {3'd0, ins[10:6]};
            end
        end else begin
            sh_amt = op_b[7:0];
            case (alu_op)
                OP_LSL:  sh_kind = SH_LSL;
                OP_LSR:  sh_kind = SH_LSR;
                OP_ASR:  sh_kind = SH_ASR;
                default: sh_kind = SH_ROR;
            endcase
        end
    end

    assign rot     = {sh_val, sh_val} >> sh_amt[4:0];
    assign asr_ext = $signed({sh_val, 1'b0}) >>> sh_amt[4:0];

    always_comb begin
        sh_res = sh_val;
        sh_c   = c_in;
        if (sh_amt != 8'd0) begin
            case (sh_kind)
                SH_LSL: begin
                    if (sh_amt <= 8'd32) begin
                        {sh_c, sh_res} = {1'b0, sh_val} << sh_amt[5:0];
                    end else begin
                        {sh_c, sh_res} = '0;
                    end
                end
                SH_LSR: begin
                    if (sh_amt <= 8'd32) begin
                        {sh_res, sh_c} = {sh_val, 1'b0} >> sh_amt[5:0];
                    end else begin
                        {sh_res, sh_c} = '0;
                    end
                end
                SH_ASR: begin
                    if (sh_amt >= 8'd32) begin
                        sh_res = {DATA_W{sh_val[DATA_W-1]}};
                        sh_c   = sh_val[DATA_W-1];
                    end else begin
                        {sh_res, sh_c} = asr_ext;
                    end
                end
                default: begin
                    sh_res = rot[DATA_W-1:0];
                    sh_c   = rot[DATA_W-1];
                end
            endcase
        end
    end

    // Result, destination and flag selection
    always_comb begin
        r       = '0;
        d       = {1'b0, ins[2:0]};
        w       = 1'b0;
        unsup   = 1'b0;
        upd_add = 1'b0;
        upd_sh  = 1'b0;
        upd_nz  = 1'b0;
        case (item.kind)
            KIND_WRITE: begin
                r = item.write_value;
                d = item.reg_index;
                w = 1'b1;
            end
            KIND_READ: begin
                r = op_a;
            end
            KIND_EXEC: begin
                case (fmt)
                    FMT_ADDSUB: begin
                        r       = add_sum[DATA_W-1:0];
                        w       = 1'b1;
                        upd_add = 1'b1;
                    end
                    FMT_SHIFT: begin
                        r      = sh_res;
                        w      = 1'b1;
                        upd_sh = 1'b1;
                    end
                    FMT_IMM: begin
                        d = {1'b0, ins[10:8]};
                        if (ins[12:11] == IMM_MOV) begin
                            r      = {24'd0, ins[7:0]};
                            w      = 1'b1;
                            upd_nz = 1'b1;
                        end else begin
                            r       = add_sum[DATA_W-1:0];
                            w       = (ins[12:11] != IMM_CMP);
                            upd_add = 1'b1;
                        end
                    end
                    FMT_ALU: begin
                        w = 1'b1;
                        case (alu_op)
                            OP_AND: begin
                                r      = op_a & op_b;
                                upd_nz = 1'b1;
                            end
                            OP_EOR: begin
                                r      = op_a ^ op_b;
                                upd_nz = 1'b1;
                            end
                            OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
                                r      = sh_res;
                                upd_sh = 1'b1;
                            end
                            OP_ADC, OP_SBC, OP_NEG: begin
                                r       = add_sum[DATA_W-1:0];
                                upd_add = 1'b1;
                            end
                            OP_TST: begin
                                r      = op_a & op_b;
                                w      = 1'b0;
                                upd_nz = 1'b1;
                            end
                            OP_CMP, OP_CMN: begin
                                r       = add_sum[DATA_W-1:0];
                                w       = 1'b0;
                                upd_add = 1'b1;
                            end
                            OP_ORR: begin
                                r      = op_a | op_b;
                                upd_nz = 1'b1;
                            end
                            OP_MUL: begin
                                r      = mul_res;
                                upd_nz = 1'b1;
                            end
                            OP_BIC: begin
                                r      = op_a & ~op_b;
                                upd_nz = 1'b1;
                            end
                            default: begin
                                r      = ~op_b;
                                upd_nz = 1'b1;
                            end
                        endcase
                    end
                    FMT_HI: begin
                        d = {ins[7], ins[2:0]};
                        case (ins[9:8])
                            HI_ADD: begin
                                r = add_sum[DATA_W-1:0];
                                w = 1'b1;
                            end
                            HI_CMP: begin
                                r       = add_sum[DATA_W-1:0];
                                upd_add = 1'b1;
                            end
                            default: begin
                                r = op_b;
                                w = 1'b1;
                            end
                        endcase
                    end
                    FMT_ADDR: begin
                        d = {1'b0, ins[10:8]};
                        r = add_sum[DATA_W-1:0];
                        w = 1'b1;
                    end
                    FMT_SP: begin
                        d = REG_SP;
                        r = add_sum[DATA_W-1:0];
                        w = 1'b1;
                    end
                    default: begin
                        unsup = 1'b1;
                    end
                endcase
            end
            default: begin
                unsup = 1'b1;
            end
        endcase
    end

    always_comb begin
        fl = flags;
        if (upd_add) begin
            fl = {r[DATA_W-1], (r == '0), add_sum[DATA_W], add_v};
        end else if (upd_sh) begin
            fl = {r[DATA_W-1], (r == '0), sh_c, flags[0]};
        end else if (upd_nz) begin
            fl = {r[DATA_W-1], (r == '0), flags[1:0]};
        end
    end

    assign res.result_value = r;
    assign res.dest_index   = w ? d : '0;
    assign res.dest_written = w;
    assign res.flags_out    = fl;
    assign res.unsupported  = unsup;

endmodule

>>> sv/thumb_alu_execute.sv
// ----------------------------------------------------------------------------
// Thumb ALU execute stage
// Executes Thumb data-processing instructions against a 16 x 32 register
// file and NZCV flags; also direct register write and read transactions.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry one transaction: execute, write register
//   or read register. m_valid/m_ready/m_payload return exactly one result per
//   transaction, in order.
//   A transaction accepted on s_ready is registered with its operands read
//   from the register file RAM; its result is computed combinationally from
//   that operand stage and registered onto m_payload when the stage advances.
//   Throughput: one transaction per cycle while m_ready keeps up. The
//   cycle is set by the operand read of the register file RAM, the 32-bit
//   adder/shifter/multiplier and write-back, in one stage with a read bypass.
//   Stall: while m_valid is held by a low m_ready, the operand stage keeps
//   its transaction and s_ready drops once that stage is full too.
//   Reset: both stages empty, all registers read as zero and flags clear at
//   once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "thumb_alu_execute_assert.svh"

module thumb_alu_execute import tae_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tae_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output tae_out_t m_payload
);

    logic               s1_valid_reg;
    tae_in_t            s1_item_reg;
    logic               m_valid_reg;
    tae_out_t           m_item_reg;
    logic [FLAGS_W-1:0] flags_reg;

    logic               accept;
    logic               adv;
    tae_rd_addr_t       rd_addr;
    logic [DATA_W-1:0]  op_a;
    logic [DATA_W-1:0]  op_b;
    tae_out_t           alu_res;

    assign adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || adv;
    assign accept  = s_valid && s_ready;
    assign rd_addr = tae_read_addrs(s_payload);

    tae_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (adv && alu_res.dest_written),
        .wr_addr (alu_res.dest_index),
        .wr_data (alu_res.result_value),
        .op_a    (op_a),
        .op_b    (op_b)
    );

    tae_alu u_alu (
        .item  (s1_item_reg),
        .op_a  (op_a),
        .op_b  (op_b),
        .flags (flags_reg),
        .res   (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            flags_reg    <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
                flags_reg   <= alu_res.flags_out;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_payload;
        end
        if (adv) begin
            m_item_reg <= alu_res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

    `TAE_ASSERT(a_s1_hold, aclk, aresetn, s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_item_reg), "operand stage lost a stalled transaction")
    `TAE_ASSERT(a_unsup_no_write, aclk, aresetn, adv && alu_res.unsupported |-> !alu_res.dest_written && alu_res.result_value == '0, "unsupported transaction writes a register")
    `TAE_ASSERT(a_unsup_flags, aclk, aresetn, adv && alu_res.unsupported |=> flags_reg == $past(flags_reg), "unsupported transaction changed the flags")
    `TAE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !s1_valid_reg && !m_valid_reg, "pipeline not empty after reset")

endmodule
